// File: hdl/rle_pkg.sv
`timescale 1ns / 1ps
// Shared constants, state encoding and control/status structs for the
// run-length expander. No dependencies.
package rle_pkg;

  // Largest run length; a longer decimal count saturates here (2..63)
  localparam int unsigned MAX_REPEAT = 32;
  // Width of the repeat count and of the copy counter
  localparam int unsigned CNT_W      = 6;
  // Width of count*10+digit before saturation
  localparam int unsigned ACC_W      = CNT_W + 4;
  localparam logic [7:0]  DIGIT_ZERO = 8'h30;
  localparam logic [7:0]  DIGIT_NINE = 8'h39;

  typedef enum logic [1:0] {
    ST_IDLE,       // taking encoded bytes
    ST_EMIT_OLD,   // expanding the run closed by a new symbol
    ST_EMIT_LAST   // expanding the final run of the stream
  } rle_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic load;       // load one decoded copy into the output register
    logic mark;       // this run ends the stream
    logic start_pend; // open a run with the pending symbol
    logic clear_run;  // drop the held run, back to no symbol
  } rle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic holding;    // a symbol is held
    logic in_digit;   // current input byte is an ASCII digit
    logic in_last;    // current input byte ends the stream
    logic out_free;   // output register can take a copy
    logic last_copy;  // next copy is the final one of the run
    logic pend_last;  // pending symbol ended the stream
  } rle_status_t;

endpackage

// File: hdl/rle_in_if.sv
`timescale 1ns / 1ps
// Encoded byte channel: valid/ready handshake with byte and last mark.
// No dependencies.
interface rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: hdl/rle_out_if.sv
`timescale 1ns / 1ps
// Decoded byte channel: valid/ready handshake with byte, last and clipped.
// No dependencies.
interface rle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       clipped;

  modport source (output valid, output out_byte, output out_last, output clipped,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input clipped,
                  output ready);
endinterface

// File: hdl/run_length_expander.sv
`timescale 1ns / 1ps
// Run-length expander top level: controller plus datapath on two streams.
// Depends on rle_pkg, rle_in_if, rle_out_if, rle_ctrl, rle_datapath.
//
// Decodes a run-length stream: a symbol byte followed by optional ASCII
// decimal digits gives that many copies (none or zero means one, counts
// above 32 saturate and every copy then carries clipped). The first byte of
// a stream is always a symbol. A run goes out when the next symbol or the
// last-marked byte arrives; the final copy carries out_last. A byte that only
// starts a run or adds a digit is taken with no hold on the input. A byte that closes a run
// holds the input while its copies (1 to 32) go out, and a last-marked byte
// adds the final run's copies as well; the controller emits one copy per
// cycle into a single output register, so output stalls stretch this.
module run_length_expander (
  input  logic      clk,
  input  logic      rst_n,
  rle_in_if.sink    in_s,
  rle_out_if.source out_s
);

  rle_pkg::rle_cmd_t    cmd;
  rle_pkg::rle_status_t status;

  rle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_s.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rle_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (in_s.in_byte),
    .in_last   (in_s.in_last),
    .out_ready (out_s.ready),
    .out_valid (out_s.valid),
    .out_byte  (out_s.out_byte),
    .out_last  (out_s.out_last),
    .clipped   (out_s.clipped)
  );

endmodule

// File: hdl/rle_datapath.sv
`timescale 1ns / 1ps
// Run-length expander datapath: held run, count accumulation, pending symbol,
// copy counter and output register. Depends on rle_pkg.
module rle_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rle_pkg::rle_cmd_t    cmd,
  output rle_pkg::rle_status_t status,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic                 clipped
);

  logic [7:0]                 held_symbol_r, held_symbol_nxt;
  logic                       holding_r, holding_nxt;
  logic [rle_pkg::CNT_W-1:0]  repeat_count_r, repeat_count_nxt;
  logic                       count_sat_r, count_sat_nxt;
  logic [7:0]                 pend_byte_r;
  logic                       pend_last_r;
  logic [rle_pkg::CNT_W-1:0]  copy_cnt_r, copy_cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r;
  logic                       out_last_r;
  logic                       clipped_r;

  logic                       in_digit;
  logic [rle_pkg::ACC_W-1:0]  acc;
  logic [rle_pkg::CNT_W-1:0]  run_len;
  logic                       last_copy;

  // Digit decode and count*10+digit as two shifts and adds
  assign in_digit = (in_byte >= rle_pkg::DIGIT_ZERO) && (in_byte <= rle_pkg::DIGIT_NINE);
  assign acc = ({4'd0, repeat_count_r} << 3) + ({4'd0, repeat_count_r} << 1)
             + {{(rle_pkg::ACC_W-8){1'b0}}, in_byte - rle_pkg::DIGIT_ZERO};

  // Copies in the held run: a zero count means one copy
  assign run_len   = (repeat_count_r == '0) ? rle_pkg::CNT_W'(1) : repeat_count_r;
  assign last_copy = (copy_cnt_r == run_len - rle_pkg::CNT_W'(1));

  assign status.holding   = holding_r;
  assign status.in_digit  = in_digit;
  assign status.in_last   = in_last;
  assign status.out_free  = !out_valid_r || out_ready;
  assign status.last_copy = last_copy;
  assign status.pend_last = pend_last_r;

  // Run state next values
  always_comb begin
    held_symbol_nxt  = held_symbol_r;
    holding_nxt      = holding_r;
    repeat_count_nxt = repeat_count_r;
    count_sat_nxt    = count_sat_r;
    if (cmd.accept) begin
      if (!holding_r) begin
        held_symbol_nxt  = in_byte;
        holding_nxt      = 1'b1;
        repeat_count_nxt = '0;
        count_sat_nxt    = 1'b0;
      end else if (in_digit) begin
        if (count_sat_r || (acc > rle_pkg::ACC_W'(rle_pkg::MAX_REPEAT))) begin
          repeat_count_nxt = rle_pkg::CNT_W'(rle_pkg::MAX_REPEAT);
          count_sat_nxt    = 1'b1;
        end else begin
          repeat_count_nxt = acc[rle_pkg::CNT_W-1:0];
        end
      end
    end
    if (cmd.start_pend) begin
      held_symbol_nxt  = pend_byte_r;
      holding_nxt      = 1'b1;
      repeat_count_nxt = '0;
      count_sat_nxt    = 1'b0;
    end
    if (cmd.clear_run) begin
      held_symbol_nxt  = '0;
      holding_nxt      = 1'b0;
      repeat_count_nxt = '0;
      count_sat_nxt    = 1'b0;
    end
  end

  // Copy counter and output register valid
  always_comb begin
    copy_cnt_nxt  = copy_cnt_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      copy_cnt_nxt  = last_copy ? '0 : copy_cnt_r + rle_pkg::CNT_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_symbol_r  <= '0;
      holding_r      <= 1'b0;
      repeat_count_r <= '0;
      count_sat_r    <= 1'b0;
      copy_cnt_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      held_symbol_r  <= held_symbol_nxt;
      holding_r      <= holding_nxt;
      repeat_count_r <= repeat_count_nxt;
      count_sat_r    <= count_sat_nxt;
      copy_cnt_r     <= copy_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers: pending symbol and output beat
  always_ff @(posedge clk) begin
    if (cmd.accept && holding_r && !in_digit) begin
      pend_byte_r <= in_byte;
      pend_last_r <= in_last;
    end
    if (cmd.load) begin
      out_byte_r <= held_symbol_r;
      out_last_r <= cmd.mark && last_copy;
      clipped_r  <= count_sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign clipped   = clipped_r;

endmodule

// File: hdl/rle_ctrl.sv
`timescale 1ns / 1ps
// Run-length expander controller: sequences byte intake and run expansion.
// Depends on rle_pkg.
module rle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rle_pkg::rle_status_t status,
  output rle_pkg::rle_cmd_t    cmd
);

  rle_pkg::rle_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rle_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      rle_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (status.holding && !status.in_digit) begin
            state_nxt = rle_pkg::ST_EMIT_OLD;
          end else if (status.in_last) begin
            state_nxt = rle_pkg::ST_EMIT_LAST;
          end
        end
      end
      rle_pkg::ST_EMIT_OLD: begin
        cmd.load = status.out_free;
        if (status.out_free && status.last_copy) begin
          cmd.start_pend = 1'b1;
          state_nxt = status.pend_last ? rle_pkg::ST_EMIT_LAST : rle_pkg::ST_IDLE;
        end
      end
      rle_pkg::ST_EMIT_LAST: begin
        cmd.load = status.out_free;
        cmd.mark = 1'b1;
        if (status.out_free && status.last_copy) begin
          cmd.clear_run = 1'b1;
          state_nxt     = rle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rle_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: bench/run_length_expander_test.sv
`timescale 1ns / 1ps
// Self-checking bench for run_length_expander: directed table plus random
// encoded streams, every decoded copy checked against a local decoder.
// Depends on rle_pkg, rle_in_if, rle_out_if and run_length_expander.
module run_length_expander_test;

  localparam int unsigned RANDOM_BEATS = 195;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned N_ROWS       = 25;

  // One decoded copy as it leaves the block
  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       clip;
  } copy_t;

  // Directed row: byte, last mark, and where obvious the run it closes
  // (copies = 0 leaves the row to the decoder model)
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic [6:0] copies;
    logic [7:0] sym;
    logic       clip;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  rle_in_if  in_ch ();
  rle_out_if out_ch ();

  run_length_expander dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus table: extremes, zero count, digit first byte, saturation,
  // exact maximum, symbol carrying the last mark, neighbors of the digit range
  row_t directed_rows [N_ROWS] = '{
    '{8'h00, 1'b0, 7'd0,  8'h00, 1'b0},
    '{"3",   1'b0, 7'd0,  8'h00, 1'b0},
    '{8'hFF, 1'b0, 7'd3,  8'h00, 1'b0},
    '{"0",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"0",   1'b1, 7'd1,  8'hFF, 1'b0},
    '{"7",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"2",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"B",   1'b1, 7'd0,  8'h00, 1'b0},
    '{"Z",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"9",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"9",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"9",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"q",   1'b0, 7'd32, "Z",   1'b1},
    '{"3",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"2",   1'b1, 7'd32, "q",   1'b0},
    '{"M",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"3",   1'b0, 7'd0,  8'h00, 1'b0},
    '{"3",   1'b1, 7'd32, "M",   1'b1},
    '{"0",   1'b1, 7'd1,  "0",   1'b0},
    '{8'h80, 1'b0, 7'd0,  8'h00, 1'b0},
    '{"/",   1'b0, 7'd1,  8'h80, 1'b0},
    '{":",   1'b0, 7'd1,  "/",   1'b0},
    '{"5",   1'b1, 7'd5,  ":",   1'b0},
    '{8'h7F, 1'b0, 7'd0,  8'h00, 1'b0},
    '{"1",   1'b1, 7'd1,  8'h7F, 1'b0}
  };

  // Decoder model state
  logic [7:0]                run_sym  = '0;
  logic                      run_open = 1'b0;
  logic [rle_pkg::CNT_W-1:0] run_len  = '0;
  logic                      run_sat  = 1'b0;

  copy_t pending_copies [$];
  copy_t fresh_copies [$];

  // Row currently offered by the sender
  logic [6:0] row_copies = '0;
  logic [7:0] row_sym    = '0;
  logic       row_clip   = 1'b0;

  int unsigned beats_sent    = 0;
  int unsigned streams_done  = 0;
  int unsigned copies_seen   = 0;
  int unsigned clipped_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned burst_left    = 0;
  bit          hold_wanted   = 1'b0;
  bit          hold_done     = 1'b0;

  // Expand the held run into fresh_copies
  task automatic flush_run(input logic mark);
    int n;
    n = (run_len == 0) ? 1 : int'(run_len);
    if (n > int'(rle_pkg::MAX_REPEAT)) n = int'(rle_pkg::MAX_REPEAT);
    for (int i = 0; i < n; i++) begin
      fresh_copies.push_back('{run_sym, mark && (i == n - 1), run_sat});
    end
  endtask

  task automatic open_run(input logic [7:0] b);
    run_sym  = b;
    run_open = 1'b1;
    run_len  = '0;
    run_sat  = 1'b0;
  endtask

  // Decode one encoded byte, leaving the copies it releases in fresh_copies
  task automatic decode_byte(input logic [7:0] b, input logic last);
    int acc;
    fresh_copies.delete();
    if (!run_open) begin
      open_run(b);
    end else if (b >= rle_pkg::DIGIT_ZERO && b <= rle_pkg::DIGIT_NINE) begin
      acc = int'(run_len) * 10 + int'(b - rle_pkg::DIGIT_ZERO);
      if (run_sat || acc > int'(rle_pkg::MAX_REPEAT)) begin
        run_len = rle_pkg::CNT_W'(rle_pkg::MAX_REPEAT);
        run_sat = 1'b1;
      end else begin
        run_len = acc[rle_pkg::CNT_W-1:0];
      end
    end else begin
      flush_run(1'b0);
      open_run(b);
    end
    if (last) begin
      flush_run(1'b1);
      run_open = 1'b0;
      run_sym  = '0;
      run_len  = '0;
      run_sat  = 1'b0;
    end
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Input beats feed the model; output beats are checked in order
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      decode_byte(in_ch.in_byte, in_ch.in_last);
      if (row_copies != 0) begin
        fresh_copies.delete();
        for (int i = 0; i < int'(row_copies); i++) begin
          fresh_copies.push_back('{row_sym, in_ch.in_last && (i == int'(row_copies) - 1),
                                   row_clip});
        end
      end
      foreach (fresh_copies[i]) pending_copies.push_back(fresh_copies[i]);
      if (in_ch.in_last) streams_done++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      copies_seen++;
      if (out_ch.clipped) clipped_seen++;
      if (pending_copies.size() == 0) begin
        $error("unexpected copy: out_byte %h out_last %b clipped %b",
               out_ch.out_byte, out_ch.out_last, out_ch.clipped);
        mismatches++;
      end else begin
        copy_t want;
        want = pending_copies.pop_front();
        if (out_ch.out_byte !== want.sym) begin
          $error("out_byte: expected %h, got %h", want.sym, out_ch.out_byte);
          mismatches++;
        end
        if (out_ch.out_last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_ch.out_last);
          mismatches++;
        end
        if (out_ch.clipped !== want.clip) begin
          $error("clipped: expected %b, got %b", want.clip, out_ch.clipped);
          mismatches++;
        end
      end
    end
  end

  // Receiver: stall pattern switched between modes, plus one long hold-off
  initial begin
    int mode;
    int mode_left;
    int phase;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_done) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        phase = (phase + 1) % 4;
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = ($urandom_range(0, 3) != 0);
          2: out_ch.ready = (phase == 0);
          default: out_ch.ready = 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Offer one beat and wait for it; bursts end in a random gap
  task automatic send_beat(input logic [7:0] b, input logic last);
    in_ch.valid   = 1'b1;
    in_ch.in_byte = b;
    in_ch.in_last = last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Well-formed stream: symbols with optional counts, last mark on the end
  task automatic send_stream();
    logic [7:0] stream_bytes [$];
    int         nsym;
    int         ndig;
    logic [7:0] sym;
    nsym = $urandom_range(1, 5);
    for (int s = 0; s < nsym; s++) begin
      if (s == 0 && $urandom_range(0, 5) == 0) begin
        sym = 8'(rle_pkg::DIGIT_ZERO + $urandom_range(0, 9));
      end else begin
        sym = 8'($urandom);
        while (sym >= rle_pkg::DIGIT_ZERO && sym <= rle_pkg::DIGIT_NINE) sym = 8'($urandom);
      end
      stream_bytes.push_back(sym);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ndig = 0;
        4, 5, 6, 7: ndig = 1;
        8:          ndig = 2;
        default:    ndig = 3;
      endcase
      repeat (ndig) stream_bytes.push_back(8'(rle_pkg::DIGIT_ZERO + $urandom_range(0, 9)));
    end
    foreach (stream_bytes[i]) send_beat(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  // Sender and run control
  initial begin
    int unsigned target;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (directed_rows[r]) begin
      row_copies = directed_rows[r].copies;
      row_sym    = directed_rows[r].sym;
      row_clip   = directed_rows[r].clip;
      send_beat(directed_rows[r].b, directed_rows[r].last);
    end
    row_copies = '0;

    // random part: mostly streams, some raw bytes with stray last marks
    hold_wanted = 1'b1;
    target = beats_sent + RANDOM_BEATS;
    while (beats_sent < target) begin
      if ($urandom_range(0, 6) != 0) begin
        send_stream();
      end else begin
        repeat ($urandom_range(1, 4)) send_beat(8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
    in_ch.valid = 1'b0;

    while (pending_copies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d encoded bytes closing %0d streams; %0d decoded copies checked.",
             beats_sent, streams_done, copies_seen);
    $display("Saturated copies seen: %0d, mismatches: %0d.", clipped_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rle_pkg.sv
hdl/rle_in_if.sv
hdl/rle_out_if.sv
hdl/rle_datapath.sv
hdl/rle_ctrl.sv
hdl/run_length_expander.sv
bench/run_length_expander_test.sv
